// File: design/spq_pkg.sv
// spq_pkg: shared types and constants of the sorted priority queue
// holds payload structs, status codes and the per-cell control struct
// no dependencies
package spq_pkg;

  localparam int unsigned DefaultDepth = 16;
  localparam int unsigned ItemW        = 16;
  localparam int unsigned PrioW        = 16;
  localparam int unsigned CountW       = 5;

  // operation kinds
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } spq_status_e;

  typedef struct packed {
    logic                    kind;
    logic [ItemW-1:0]        item_in;
    logic signed [PrioW-1:0] priority_in;
  } spq_in_t;

  typedef struct packed {
    logic [1:0]              status;
    logic [ItemW-1:0]        item_out;
    logic signed [PrioW-1:0] priority_out;
    logic [CountW-1:0]       count;
  } spq_out_t;

  typedef struct packed {
    logic [ItemW-1:0]        item;
    logic signed [PrioW-1:0] prio;
  } spq_entry_t;

  // broadcast from the top level to every cell
  typedef struct packed {
    logic       insert;
    logic       remove;
    spq_entry_t entry;
  } spq_ctrl_t;

endpackage

// File: design/spq_cell.sv
// spq_cell: one slot of the sorted chain, holds one entry
// compares its priority against the broadcast entry and shifts with its neighbours
// depends on spq_pkg
module spq_cell (
  input  logic               clk_i,
  input  spq_pkg::spq_ctrl_t ctrl_i,
  input  logic               valid_i,
  input  logic               left_ge_i,
  input  spq_pkg::spq_entry_t left_i,
  input  spq_pkg::spq_entry_t right_i,
  output spq_pkg::spq_entry_t entry_o,
  output logic               ge_o
);
  import spq_pkg::*;

  spq_entry_t entry_q, entry_d;

  // entry stays ahead of a new one of equal priority
  assign ge_o = valid_i && (entry_q.prio >= ctrl_i.entry.prio);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.insert && !ge_o) begin
      // first cell below the insertion point takes the new entry, the rest shift down
      entry_d = left_ge_i ? ctrl_i.entry : left_i;
    end else if (ctrl_i.remove) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// File: design/sorted_priority_queue_top.sv
// sorted_priority_queue_top: sorted priority queue built as a chain of compare-and-shift cells
// holds the entry count, the output register and the row of spq_cell instances
// depends on spq_pkg and spq_cell
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+------------------
//   in      | into      | in_valid_i / in_stall_o    | spq_in_t in_data_i
//   out     | out of    | out_valid_o / out_stall_i  | spq_out_t out_data_o
//
// every cell compares and shifts at the same edge, so an insert or remove completes
// at the edge that takes the transfer, and the result is loaded into the output register
// at that same edge
// reset clears the count and output valid; entry contents are left undefined
// the input stalls only while a result is held and the output side stalls
module sorted_priority_queue_top #(
  parameter int unsigned DEPTH = spq_pkg::DefaultDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  spq_pkg::spq_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output spq_pkg::spq_out_t out_data_o
);
  import spq_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [CW-1:0] count_q, count_d;
  logic          out_valid_q;
  spq_out_t      out_data_q, out_data_d;

  logic       accept;
  logic       is_full, is_empty;
  spq_ctrl_t  ctrl;
  spq_entry_t ent [DEPTH];
  logic       ge  [DEPTH];

  // a finished result parts the two sides; input waits only if it cannot leave
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign is_full  = (count_q == CW'(DEPTH));
  assign is_empty = (count_q == '0);

  // control broadcast to the whole row
  assign ctrl.insert     = accept && (in_data_i.kind == KIND_INSERT) && !is_full;
  assign ctrl.remove     = accept && (in_data_i.kind == KIND_REMOVE) && !is_empty;
  assign ctrl.entry.item = in_data_i.item_in;
  assign ctrl.entry.prio = in_data_i.priority_in;

  // the cell row, front at index zero
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    spq_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .valid_i   (CW'(g) < count_q),
      .left_ge_i ((g == 0) ? 1'b1 : ge[(g == 0) ? 0 : g - 1]),
      .left_i    ((g == 0) ? ctrl.entry : ent[(g == 0) ? 0 : g - 1]),
      .right_i   ((g == DEPTH - 1) ? ent[g] : ent[(g == DEPTH - 1) ? g : g + 1]),
      .entry_o   (ent[g]),
      .ge_o      (ge[g])
    );
  end

  // count update and the result of this transfer
  always_comb begin
    count_d                 = count_q;
    out_data_d.status       = ST_DONE;
    out_data_d.item_out     = '0;
    out_data_d.priority_out = '0;
    if (in_data_i.kind == KIND_INSERT) begin
      if (is_full) begin
        out_data_d.status = ST_FULL;
      end else begin
        count_d = count_q + 1'b1;
      end
    end else begin
      if (is_empty) begin
        out_data_d.status = ST_EMPTY;
      end else begin
        count_d                 = count_q - 1'b1;
        out_data_d.item_out     = ent[0].item;
        out_data_d.priority_out = ent[0].prio;
      end
    end
    out_data_d.count = CountW'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, loaded on each transfer in
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
